// ===== rtl/lpes_pkg.sv =====
`timescale 1ns / 1ps

package lpes_pkg;

  localparam int unsigned ByteW          = 8;
  localparam int unsigned OffsetW        = 32;
  localparam int unsigned CountW         = 8;
  // enough bits to hold MaxVarintBytes
  localparam int unsigned VarintCntW     = 3;
  localparam int unsigned MaxVarintBytes = 5;

  // one accepted word presented to the walker
  typedef struct packed {
    logic             step;
    logic             start;
    logic [ByteW-1:0] data;
  } lpes_step_t;

  // result produced by the walker for that word
  typedef struct packed {
    logic               valid;
    logic [OffsetW-1:0] offset;
    logic               malformed;
  } lpes_res_t;

endpackage

// ===== rtl/lpes_in_if.sv =====
`timescale 1ns / 1ps

interface lpes_in_if import lpes_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// ===== rtl/lpes_out_if.sv =====
`timescale 1ns / 1ps

interface lpes_out_if import lpes_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OffsetW-1:0] offset;
  logic               malformed;

  modport source (output valid, output offset, output malformed, input ready);
  modport sink   (input valid, input offset, input malformed, output ready);
endinterface

// ===== rtl/length_prefixed_entry_skipper_core.sv =====
`timescale 1ns / 1ps
// A word accepted into the input register is walked when it advances; its result is offered from the output register.
// Throughput: one byte per cycle while no result waits untaken; the walk state is updated once per byte.
// Input and output registers part the two sides; the input stalls only while
// the output holds an untaken result and a further byte is already waiting.
// Reset: asynchronous, active low; walker idle, entry count register cleared.

module length_prefixed_entry_skipper_core import lpes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  lpes_in_if.sink           in_i,
  lpes_out_if.source        out_o
);

  logic [CountW-1:0]  skip_q;
  logic               s1_valid_q, s1_valid_d;
  logic [ByteW-1:0]   s1_data_q;
  logic               s1_start_q;
  logic               out_valid_q, out_valid_d;
  logic [OffsetW-1:0] out_offset_q;
  logic               out_malformed_q;
  logic               in_acc;
  logic               advance;
  lpes_step_t         step;
  lpes_res_t          res;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  assign step.step  = advance;
  assign step.start = s1_start_q;
  assign step.data  = s1_data_q;

  lpes_walker u_walker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .entries_to_skip_i (skip_q),
    .res_o             (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        skip_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q  <= in_i.data_byte;
      s1_start_q <= in_i.start_req;
    end
    if (advance && res.valid) begin
      out_offset_q    <= res.offset;
      out_malformed_q <= res.malformed;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.offset    = out_offset_q;
  assign out_o.malformed = out_malformed_q;

endmodule

// ===== rtl/lpes_walker.sv =====
`timescale 1ns / 1ps

module lpes_walker import lpes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpes_step_t        step_i,
  input  logic [CountW-1:0] entries_to_skip_i,
  output lpes_res_t         res_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhKlen  = 3'd1;
  localparam logic [2:0] PhKbody = 3'd2;
  localparam logic [2:0] PhVlen  = 3'd3;
  localparam logic [2:0] PhVbody = 3'd4;

  logic [2:0]            phase_q, phase_d;
  logic [OffsetW-1:0]    accum_q, accum_d;
  logic [VarintCntW-1:0] vbytes_q, vbytes_d;
  logic [OffsetW-1:0]    body_q, body_d;
  logic [CountW-1:0]     done_q, done_d;
  logic [OffsetW-1:0]    count_q, count_d;

  // state as seen after a start word has cleared it
  logic [2:0]            ph_s;
  logic [OffsetW-1:0]    accum_s;
  logic [VarintCntW-1:0] vbytes_s;
  logic [OffsetW-1:0]    body_s;
  logic [CountW-1:0]     done_s;
  logic [OffsetW-1:0]    count_s;

  logic [OffsetW-1:0]    group_sh;
  logic [OffsetW-1:0]    accum_new;
  logic [VarintCntW-1:0] vbytes_new;
  logic [OffsetW-1:0]    count_new;
  logic [CountW-1:0]     done_new;
  logic                  entry_end;
  logic                  consume;

  // place the 7-bit group at its position; upper bits of the fifth group drop off
  always_comb begin
    case (vbytes_s)
      3'd0:    group_sh = {25'd0, step_i.data[6:0]};
      3'd1:    group_sh = {18'd0, step_i.data[6:0], 7'd0};
      3'd2:    group_sh = {11'd0, step_i.data[6:0], 14'd0};
      3'd3:    group_sh = {4'd0, step_i.data[6:0], 21'd0};
      3'd4:    group_sh = {step_i.data[3:0], 28'd0};
      default: group_sh = '0;
    endcase
  end

  assign accum_new  = accum_s | group_sh;
  assign vbytes_new = vbytes_s + 1'b1;
  assign count_new  = count_s + 1'b1;
  assign done_new   = done_s + 1'b1;

  always_comb begin
    ph_s     = phase_q;
    accum_s  = accum_q;
    vbytes_s = vbytes_q;
    body_s   = body_q;
    done_s   = done_q;
    count_s  = count_q;
    consume  = 1'b1;
    if (step_i.start) begin
      ph_s     = PhKlen;
      accum_s  = '0;
      vbytes_s = '0;
      body_s   = '0;
      done_s   = '0;
      count_s  = '0;
      consume  = (entries_to_skip_i != '0);
    end
  end

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    vbytes_d  = vbytes_q;
    body_d    = body_q;
    done_d    = done_q;
    count_d   = count_q;
    entry_end = 1'b0;
    res_o     = '0;
    if (step_i.step) begin
      phase_d  = ph_s;
      accum_d  = accum_s;
      vbytes_d = vbytes_s;
      body_d   = body_s;
      done_d   = done_s;
      count_d  = count_s;
      if (!consume) begin
        // zero count: report offset 0 on the start word itself
        phase_d     = PhIdle;
        res_o.valid = 1'b1;
      end else begin
        unique case (ph_s) inside
          PhKlen, PhVlen: begin
            count_d = count_new;
            if (step_i.data[7]) begin
              accum_d  = accum_new;
              vbytes_d = vbytes_new;
              if (vbytes_new >= VarintCntW'(MaxVarintBytes)) begin
                phase_d         = PhIdle;
                res_o.valid     = 1'b1;
                res_o.malformed = 1'b1;
              end
            end else begin
              body_d   = accum_new;
              accum_d  = '0;
              vbytes_d = '0;
              if (ph_s == PhKlen) begin
                phase_d = (accum_new == '0) ? PhVlen : PhKbody;
              end else if (accum_new == '0) begin
                entry_end = 1'b1;
              end else begin
                phase_d = PhVbody;
              end
            end
          end
          PhKbody: begin
            count_d = count_new;
            body_d  = body_s - 1'b1;
            if (body_s == OffsetW'(1)) begin
              phase_d = PhVlen;
            end
          end
          PhVbody: begin
            count_d = count_new;
            body_d  = body_s - 1'b1;
            if (body_s == OffsetW'(1)) begin
              entry_end = 1'b1;
            end
          end
          default: begin
            // idle: word ignored
          end
        endcase

        if (entry_end) begin
          done_d = done_new;
          if (done_new >= entries_to_skip_i) begin
            phase_d      = PhIdle;
            res_o.valid  = 1'b1;
            res_o.offset = count_new;
          end else begin
            phase_d  = PhKlen;
            accum_d  = '0;
            vbytes_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      accum_q  <= '0;
      vbytes_q <= '0;
      body_q   <= '0;
      done_q   <= '0;
      count_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      vbytes_q <= vbytes_d;
      body_q   <= body_d;
      done_q   <= done_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/lpes_checker.sv =====
`timescale 1ns / 1ps

module lpes_checker import lpes_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [OffsetW-1:0] out_offset_i,
  input logic               out_malformed_i
);

  // a held result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // a malformed walk reports offset zero
  a_bad_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_malformed_i |-> out_offset_i == '0)
    else $error("malformed result with nonzero offset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output free");

  // a fresh result comes from an input word that passed the input register and the walker
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching input word");

endmodule

bind length_prefixed_entry_skipper_core lpes_checker u_lpes_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_offset_i    (out_o.offset),
  .out_malformed_i (out_o.malformed)
);
